/* hw/rtl/ept_pkg.sv */
// shared types, constants and helper functions for the extreme point box tracker
// no dependencies; imported by every module of the block
package ept_pkg;

  localparam int TIME_STEPS = 64;
  localparam int IDX_W      = $clog2(TIME_STEPS);
  localparam int WORD_W     = 32;
  localparam int AXES       = 3;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] PLANE_XY = 2'd0;
  localparam logic [1:0] PLANE_YZ = 2'd1;
  localparam logic [1:0] PLANE_XZ = 2'd2;

  localparam logic [WORD_W-1:0] POS_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] NEG_MAX = {1'b1, {(WORD_W-1){1'b0}}};

  typedef logic [AXES-1:0][WORD_W-1:0] vec_t;
  typedef logic signed [WORD_W:0] proj_t;

  typedef struct packed {
    vec_t hi_sh;
    vec_t lo_sh;
    vec_t hi;
    vec_t lo;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  // memory access request
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } mem_req_t;

  function automatic row_t empty_row();
    row_t r;
    for (int a = 0; a < AXES; a++) begin
      r.lo[a]    = POS_MAX;
      r.hi[a]    = NEG_MAX;
      r.lo_sh[a] = '0;
      r.hi_sh[a] = '0;
    end
    return r;
  endfunction

  // sum of the two coordinates lying in the selected plane
  function automatic proj_t project(input logic [1:0] plane, input vec_t p);
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    case (plane)
      PLANE_YZ: begin
        a = p[1];
        b = p[2];
      end
      PLANE_XZ: begin
        a = p[0];
        b = p[2];
      end
      default: begin
        a = p[0];
        b = p[1];
      end
    endcase
    return $signed({a[WORD_W-1], a}) + $signed({b[WORD_W-1], b});
  endfunction

endpackage

/* hw/rtl/extreme_point_box_tracker_unit.sv */
// extreme point box tracker: one min/max box per time step, updated per mesh point
// depends on ept_pkg, ept_store and ept_update
//
// usage
//   in_*  : requests (clear entry, add point, read entry) addressed by time step;
//           in_tlast marks the last point of a run, which makes an add emit the box
//   out_* : the box of the addressed entry after a read or a last-point add
//   cfg_* : plane select for plane-extreme mode, written while the block is idle
// timing
//   one request accepted per cycle when the output side keeps up; a result
//   appears on out_tvalid after its request has passed the request stage (the
//   table read registers on the accepting edge) and then the result register
//   back-to-back requests to the same entry are served by a write bypass
// reset
//   every entry reads as an empty box (min corner most positive, max corner most
//   negative, displacements zero); valid bits per entry, no clearing pass
//   plane select returns to the xy plane
// stall
//   a held result keeps an occupied request stage waiting; in_tready then drops
//   until out_tready takes the result
module extreme_point_box_tracker_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // time_step, pos_x, pos_y, pos_z, shift_x, shift_y, shift_z, zero pad
  input  logic [199:0] in_tdata,
  // op, with_shift
  input  logic [2:0]   in_tuser,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // low_x/y/z, high_x/y/z, low_shift_x/y/z, high_shift_x/y/z
  output logic [383:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_data
);
  import ept_pkg::*;

  logic [1:0]       plane_r;
  logic             s1_vld_r;
  logic [1:0]       s1_op_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic             s1_shift_r;
  logic             s1_last_r;
  vec_t             s1_pos_r;
  vec_t             s1_sh_r;
  logic             out_vld_r;
  row_t             out_row_r;

  logic     in_fire;
  logic     s1_adv;
  mem_req_t rd_req;
  mem_req_t wr_req;
  row_t     cur_row;
  row_t     nxt_row;
  logic     upd_wr;
  logic     upd_emit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r <= PLANE_XY;
    end else if (cfg_valid) begin
      plane_r <= cfg_data;
    end
  end

  assign s1_adv    = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  assign rd_req.en   = in_fire;
  assign rd_req.addr = in_tdata[IDX_W-1:0];
  assign wr_req.en   = s1_adv && upd_wr;
  assign wr_req.addr = s1_idx_r;

  ept_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_req  (rd_req),
    .wr_req  (wr_req),
    .wr_data (nxt_row),
    .rd_row  (cur_row)
  );

  ept_update u_update (
    .op         (s1_op_r),
    .with_shift (s1_shift_r),
    .last_point (s1_last_r),
    .plane      (plane_r),
    .pos        (s1_pos_r),
    .shift      (s1_sh_r),
    .cur        (cur_row),
    .nxt        (nxt_row),
    .wr_en      (upd_wr),
    .emit       (upd_emit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r     <= in_tuser[1:0];
      s1_shift_r  <= in_tuser[2];
      s1_last_r   <= in_tlast;
      s1_idx_r    <= in_tdata[IDX_W-1:0];
      s1_pos_r[0] <= in_tdata[37:6];
      s1_pos_r[1] <= in_tdata[69:38];
      s1_pos_r[2] <= in_tdata[101:70];
      s1_sh_r[0]  <= in_tdata[133:102];
      s1_sh_r[1]  <= in_tdata[165:134];
      s1_sh_r[2]  <= in_tdata[197:166];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv && upd_emit) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && upd_emit) begin
      out_row_r <= nxt_row;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_row_r.hi_sh[2], out_row_r.hi_sh[1], out_row_r.hi_sh[0],
                       out_row_r.lo_sh[2], out_row_r.lo_sh[1], out_row_r.lo_sh[0],
                       out_row_r.hi[2], out_row_r.hi[1], out_row_r.hi[0],
                       out_row_r.lo[2], out_row_r.lo[1], out_row_r.lo[0]};

endmodule

/* hw/rtl/ept_store.sv */
// box table: one row per time step, registered read, valid bit per row
// and a write-to-read bypass; depends on ept_pkg
module ept_store (
  input  logic              clk,
  input  logic              rst_n,
  input  ept_pkg::mem_req_t rd_req,
  input  ept_pkg::mem_req_t wr_req,
  input  ept_pkg::row_t     wr_data,
  output ept_pkg::row_t     rd_row
);
  import ept_pkg::*;

  logic [ROW_W-1:0]      mem [TIME_STEPS];
  logic [ROW_W-1:0]      mem_q_r;
  logic [IDX_W-1:0]      rd_addr_r;
  logic [TIME_STEPS-1:0] vld_r;
  logic                  fwd_vld_r;
  logic [IDX_W-1:0]      fwd_addr_r;
  row_t                  fwd_data_r;

  always_ff @(posedge clk) begin
    if (wr_req.en) begin
      mem[wr_req.addr] <= wr_data;
    end
    if (rd_req.en) begin
      mem_q_r   <= mem[rd_req.addr];
      rd_addr_r <= rd_req.addr;
    end
    if (wr_req.en) begin
      fwd_addr_r <= wr_req.addr;
      fwd_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      fwd_vld_r <= 1'b0;
    end else if (wr_req.en) begin
      vld_r[wr_req.addr] <= 1'b1;
      fwd_vld_r          <= 1'b1;
    end
  end

  // row written on the same edge as the read wins over the stale read data
  always_comb begin
    if (fwd_vld_r && (fwd_addr_r == rd_addr_r)) begin
      rd_row = fwd_data_r;
    end else if (vld_r[rd_addr_r]) begin
      rd_row = row_t'(mem_q_r);
    end else begin
      rd_row = empty_row();
    end
  end

endmodule

/* hw/rtl/ept_update.sv */
// combinational row update for clear, add point and read requests
// depends on ept_pkg
module ept_update (
  input  logic          [1:0] op,
  input  logic                with_shift,
  input  logic                last_point,
  input  logic          [1:0] plane,
  input  ept_pkg::vec_t       pos,
  input  ept_pkg::vec_t       shift,
  input  ept_pkg::row_t       cur,
  output ept_pkg::row_t       nxt,
  output logic                wr_en,
  output logic                emit
);
  import ept_pkg::*;

  proj_t d;
  proj_t lo_p;
  proj_t hi_p;

  always_comb begin
    d    = project(plane, pos);
    lo_p = project(plane, cur.lo);
    hi_p = project(plane, cur.hi);
    nxt  = cur;
    wr_en = 1'b0;
    emit  = 1'b0;
    unique case (op)
      OP_CLEAR: begin
        nxt   = empty_row();
        wr_en = 1'b1;
      end
      OP_ADD: begin
        wr_en = 1'b1;
        emit  = last_point;
        if (with_shift) begin
          if (d < lo_p) begin
            nxt.lo    = pos;
            nxt.lo_sh = shift;
          end
          if (d > hi_p) begin
            nxt.hi    = pos;
            nxt.hi_sh = shift;
          end
        end else begin
          for (int a = 0; a < AXES; a++) begin
            if ($signed(pos[a]) > $signed(cur.hi[a])) begin
              nxt.hi[a] = pos[a];
            end
            if ($signed(pos[a]) < $signed(cur.lo[a])) begin
              nxt.lo[a] = pos[a];
            end
          end
        end
      end
      OP_READ: begin
        emit = 1'b1;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

endmodule
